### hdl/fbgc_pkg.sv
// Shared types and constants for the FAT12 boot sector geometry checker.
// Used by fbgc_calc and fat12_bpb_geometry_check; no dependencies.
`default_nettype none

package fbgc_pkg;

   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 96;

   localparam logic [15:0] REQUIRED_SECTOR_LEN = 16'd512;
   localparam int          SECTOR_SHIFT        = 9;
   localparam int          ENTRY_PER_SEC_SHIFT = 4;     // 512 / 32 entries per sector
   localparam logic [7:0]  MAX_CLUSTER_SECTORS = 8'd128;
   localparam logic [15:0] CLUSTER_LIMIT       = 16'd4085;
   localparam logic [1:0]  FAT12_NUM           = 2'd3;  // 3 bytes per 2 entries

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_BAD_BPB  = 2'd1,
      ST_NO_ROOM  = 2'd2,
      ST_BAD_GEOM = 2'd3
   } status_type;

   typedef struct packed {
      logic [15:0] sector_bytes;
      logic [7:0]  cluster_sectors;
      logic [15:0] reserved_count;
      logic [7:0]  fat_copies;
      logic [15:0] root_entry_count;
      logic [15:0] volume_sectors;
      logic [15:0] fat_sectors;
   } bpb_type;

   typedef struct packed {
      status_type  status;
      logic [23:0] root_start;
      logic [12:0] root_length;
      logic [24:0] data_start;
      logic [16:0] cluster_bytes;
      logic [11:0] cluster_total;
   } geom_type;

endpackage

`default_nettype wire

### hdl/fbgc_calc.sv
// Geometry and validity evaluation for one parameter block.
// Combinational; sits between the input and result registers. Uses fbgc_pkg.
`default_nettype none

module fbgc_calc import fbgc_pkg::*; (
   input  bpb_type  bpb,
   output geom_type geom
);

   logic        spc_ok;
   logic        bad_bpb;
   logic [23:0] fat_area;
   logic [23:0] root_start;
   logic [12:0] root_length;
   logic [24:0] data_start;
   logic [16:0] cluster_bytes;
   logic        no_room;
   logic [15:0] free_sectors;
   logic [2:0]  spc_log2;
   logic [15:0] clusters;
   logic [17:0] fat_need;
   logic [24:0] fat_cap;
   logic        bad_geom;

   assign spc_ok = (bpb.cluster_sectors != 8'd0) &&
                   ((bpb.cluster_sectors & (bpb.cluster_sectors - 8'd1)) == 8'd0) &&
                   (bpb.cluster_sectors <= MAX_CLUSTER_SECTORS);

   assign bad_bpb = (bpb.sector_bytes != REQUIRED_SECTOR_LEN) || !spc_ok ||
                    (bpb.reserved_count == 16'd0) || (bpb.root_entry_count == 16'd0) ||
                    (bpb.fat_copies == 8'd0) || (bpb.fat_sectors == 16'd0);

   assign fat_area      = bpb.fat_copies * bpb.fat_sectors;
   assign root_start    = {8'd0, bpb.reserved_count} + fat_area;
   // ceil(entries * 32 / 512) == (entries + 15) >> 4
   assign root_length   = 13'(({1'b0, bpb.root_entry_count} + 17'd15) >> ENTRY_PER_SEC_SHIFT);
   assign data_start    = {1'b0, root_start} + {12'd0, root_length};
   assign cluster_bytes = {bpb.cluster_sectors, {SECTOR_SHIFT{1'b0}}};

   assign no_room      = data_start >= {9'd0, bpb.volume_sectors};
   assign free_sectors = bpb.volume_sectors - data_start[15:0];

   always_comb begin
      spc_log2 = 3'd0;
      for (int i = 0; i < 8; i++) begin
         if (bpb.cluster_sectors[i]) begin
            spc_log2 = 3'(i);
         end
      end
   end

   assign clusters = free_sectors >> spc_log2;
   assign fat_need = 18'(((({2'd0, clusters} + 18'd2) * FAT12_NUM) + 18'd1) >> 1);
   assign fat_cap  = {bpb.fat_sectors, {SECTOR_SHIFT{1'b0}}};
   assign bad_geom = (clusters == 16'd0) || (clusters >= CLUSTER_LIMIT) ||
                     ({7'd0, fat_need} > fat_cap);

   always_comb begin
      geom.status        = ST_OK;
      geom.root_start    = root_start;
      geom.root_length   = root_length;
      geom.data_start    = data_start;
      geom.cluster_bytes = cluster_bytes;
      geom.cluster_total = 12'd0;
      if (bad_bpb) begin
         geom.status        = ST_BAD_BPB;
         geom.root_start    = 24'd0;
         geom.root_length   = 13'd0;
         geom.data_start    = 25'd0;
         geom.cluster_bytes = 17'd0;
      end else if (no_room) begin
         geom.status = ST_NO_ROOM;
      end else if (bad_geom) begin
         geom.status = ST_BAD_GEOM;
      end else begin
         geom.cluster_total = clusters[11:0];
      end
   end

endmodule

`default_nettype wire

### hdl/fat12_bpb_geometry_check.sv
// FAT12 boot sector parameter check: validates one parameter block per transaction
// and returns status plus root, data and cluster geometry.
// Path: input register, combinational fbgc_calc, result register driving rsp_tvalid.
// Throughput: one transaction per cycle unless rsp_tready stalls; the result register lets a
// new request in while a finished result waits on rsp_tready.
// Reset: synchronous, clears both valid flags; payload registers are not reset.
`default_nettype none

module fat12_bpb_geometry_check import fbgc_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // sector_bytes[15:0], cluster_sectors[23:16], reserved_count[39:24],
   // fat_copies[47:40], root_entry_count[63:48], volume_sectors[79:64],
   // fat_sectors[95:80]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // status[1:0], root_start[25:2], root_length[38:26], data_start[63:39],
   // cluster_bytes[80:64], cluster_total[92:81], zero[95:93]
   output logic [RSP_DATA_W-1:0]      rsp_tdata
);

   bpb_type  bpb_ff, bpb_in;
   logic     req_valid_ff, req_valid_in;
   geom_type rsp_ff, rsp_in;
   logic     rsp_valid_ff, rsp_valid_in;
   geom_type geom;
   logic     advance;

   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;

   always_comb begin
      bpb_in.sector_bytes     = req_tdata[15:0];
      bpb_in.cluster_sectors  = req_tdata[23:16];
      bpb_in.reserved_count   = req_tdata[39:24];
      bpb_in.fat_copies       = req_tdata[47:40];
      bpb_in.root_entry_count = req_tdata[63:48];
      bpb_in.volume_sectors   = req_tdata[79:64];
      bpb_in.fat_sectors      = req_tdata[95:80];
   end

   fbgc_calc u_calc (
      .bpb  (bpb_ff),
      .geom (geom)
   );

   assign rsp_in = geom;

   always_comb begin
      req_valid_in = req_valid_ff;
      if (req_tready) begin
         req_valid_in = req_tvalid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         bpb_ff <= bpb_in;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, rsp_ff.cluster_total, rsp_ff.cluster_bytes, rsp_ff.data_start,
                        rsp_ff.root_length, rsp_ff.root_start, rsp_ff.status};

   // a held request stays held until the result register frees up
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && !advance |=> req_valid_ff && $stable(bpb_ff))
      else $error("pending request dropped or changed");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && !advance |-> rsp_valid_ff && !rsp_tready)
      else $error("input stage stalled without output backpressure");

   a_ok_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_ff.status == ST_OK) == (rsp_ff.cluster_total != 12'd0)))
      else $error("cluster count inconsistent with status");

   a_bad_bpb_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == ST_BAD_BPB |->
         rsp_ff.root_start == 24'd0 && rsp_ff.data_start == 25'd0 &&
         rsp_ff.cluster_bytes == 17'd0)
      else $error("geometry not cleared on bad parameter block");

endmodule

`default_nettype wire

### bench/fat12_geometry_monitor.sv
// Monitor and scoreboard for fat12_bpb_geometry_check: predicts each result from the
// accepted parameter block and compares it field by field. Depends on fbgc_pkg.
`default_nettype none

module fat12_geometry_monitor import fbgc_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic [RSP_DATA_W-1:0] rsp_tdata,
   output int unsigned                results_waiting,
   output int                         error_total
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned SECTOR_BYTE_COUNT = 512;
   localparam int unsigned DIR_ENTRY_SIZE    = 32;
   localparam int unsigned MAX_SPC           = 128;
   localparam int unsigned CLUSTER_CEILING   = 4085;

   geom_type expected_geometry[$];
   int       errors = 0;

   assign error_total = errors;

   function automatic geom_type predict_geometry(input bpb_type b);
      geom_type    g;
      int unsigned spc, rsv, nfat, nroot, vol, fsz;
      int unsigned root_len, root_first, data_first, sh, clusters;
      g = '0;
      spc   = b.cluster_sectors;
      rsv   = b.reserved_count;
      nfat  = b.fat_copies;
      nroot = b.root_entry_count;
      vol   = b.volume_sectors;
      fsz   = b.fat_sectors;
      if (b.sector_bytes != SECTOR_BYTE_COUNT || spc == 0 || (spc & (spc - 1)) != 0 ||
          spc > MAX_SPC || rsv == 0 || nroot == 0 || nfat == 0 || fsz == 0) begin
         g.status = ST_BAD_BPB;
         return g;
      end
      root_len   = (nroot * DIR_ENTRY_SIZE + SECTOR_BYTE_COUNT - 1) / SECTOR_BYTE_COUNT;
      root_first = rsv + nfat * fsz;
      data_first = root_first + root_len;
      g.root_start    = 24'(root_first);
      g.root_length   = 13'(root_len);
      g.data_start    = 25'(data_first);
      g.cluster_bytes = 17'(SECTOR_BYTE_COUNT * spc);
      if (data_first >= vol) begin
         g.status = ST_NO_ROOM;
         return g;
      end
      sh = 0;
      while (sh < 7 && (1 << sh) != spc)
         sh++;
      clusters = (vol - data_first) >> sh;
      // FAT12 packs two entries into three bytes; clusters 0 and 1 are reserved
      if (clusters == 0 || clusters >= CLUSTER_CEILING ||
          ((clusters + 2) * 3 + 1) / 2 > fsz * SECTOR_BYTE_COUNT) begin
         g.status = ST_BAD_GEOM;
         return g;
      end
      g.status        = ST_OK;
      g.cluster_total = 12'(clusters);
      return g;
   endfunction

   task automatic check_field(input string label, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", label, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : sample
      bpb_type  seen;
      geom_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_geometry.size() == 0) begin
               $error("result transaction with none outstanding: %h", rsp_tdata);
               errors++;
            end else begin
               want = expected_geometry.pop_front();
               check_field("status",        want.status,        rsp_tdata[1:0]);
               check_field("root_start",    want.root_start,    rsp_tdata[25:2]);
               check_field("root_length",   want.root_length,   rsp_tdata[38:26]);
               check_field("data_start",    want.data_start,    rsp_tdata[63:39]);
               check_field("cluster_bytes", want.cluster_bytes, rsp_tdata[80:64]);
               check_field("cluster_total", want.cluster_total, rsp_tdata[92:81]);
               check_field("padding",       0,                  rsp_tdata[95:93]);
            end
         end
         if (req_tvalid && req_tready) begin
            seen.sector_bytes     = req_tdata[15:0];
            seen.cluster_sectors  = req_tdata[23:16];
            seen.reserved_count   = req_tdata[39:24];
            seen.fat_copies       = req_tdata[47:40];
            seen.root_entry_count = req_tdata[63:48];
            seen.volume_sectors   = req_tdata[79:64];
            seen.fat_sectors      = req_tdata[95:80];
            expected_geometry.push_back(predict_geometry(seen));
         end
         results_waiting <= expected_geometry.size();
      end
   end

endmodule

`default_nettype wire

### bench/fat12_bpb_geometry_check_tb.sv
// Testbench top for fat12_bpb_geometry_check: clock, reset, directed and random boot
// sector parameter blocks, result backpressure and the verdict.
// Depends on fbgc_pkg, the block and fat12_geometry_monitor.
`default_nettype none

module fat12_bpb_geometry_check_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import fbgc_pkg::*;

   localparam int RANDOM_ITEMS = 1930;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   int unsigned           results_waiting;
   int                    error_total;
   bit                    no_gaps = 1'b0;

   fat12_bpb_geometry_check dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   fat12_geometry_monitor geometry_monitor (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .results_waiting (results_waiting),
      .error_total     (error_total)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #(10ms);
      $display("fat12_bpb_geometry_check_tb failed");
      $finish;
   end

   // mostly short idles, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic offer_bpb(input logic [15:0] sector_bytes, input logic [7:0] spc,
                            input logic [15:0] rsv, input logic [7:0] nfat,
                            input logic [15:0] nroot, input logic [15:0] vol,
                            input logic [15:0] fsz);
      int unsigned gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {fsz, vol, nroot, nfat, rsv, spc, sector_bytes};
      do @(posedge clock); while (!req_tready);
      gap = no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin : stimulus
      int unsigned spc, rsv, nfat, nroot, fsz, meta, vol, room, kind;
      int unsigned sb;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      offer_bpb(512, 1, 1, 2, 224, 2880, 9);        // 1.44M floppy
      offer_bpb(512, 2, 1, 2, 112, 1440, 3);        // 720K floppy
      offer_bpb(0, 1, 1, 2, 224, 2880, 9);
      offer_bpb(16'hFFFF, 1, 1, 2, 224, 2880, 9);
      offer_bpb(1024, 1, 1, 2, 224, 2880, 9);
      offer_bpb(512, 0, 1, 2, 224, 2880, 9);
      offer_bpb(512, 3, 1, 2, 224, 2880, 9);
      offer_bpb(512, 255, 1, 2, 224, 2880, 9);
      offer_bpb(512, 128, 1, 1, 16, 65535, 12);     // largest cluster
      offer_bpb(512, 1, 0, 2, 224, 2880, 9);
      offer_bpb(512, 1, 1, 2, 0, 2880, 9);
      offer_bpb(512, 1, 1, 0, 224, 2880, 9);
      offer_bpb(512, 1, 1, 2, 224, 2880, 0);
      offer_bpb(512, 1, 1, 2, 224, 33, 9);          // data start equals volume size
      offer_bpb(512, 128, 65535, 255, 65535, 65535, 65535);
      offer_bpb(512, 4, 1, 2, 224, 34, 9);          // remainder shifts to zero clusters
      offer_bpb(512, 1, 1, 1, 16, 65535, 12);       // too many clusters
      offer_bpb(512, 1, 1, 1, 16, 4098, 12);        // largest legal count
      offer_bpb(512, 1, 1, 1, 16, 4099, 12);        // one past it
      offer_bpb(512, 1, 1, 2, 224, 2880, 1);        // FAT copy too small
      offer_bpb(512, 1, 1, 1, 16, 4, 1);            // single cluster
      offer_bpb(512, 1, 1, 2, 1, 2880, 9);          // root rounds up to one sector
      offer_bpb(512, 8, 1, 1, 65535, 65535, 4);
      offer_bpb(512, 64, 1, 255, 16, 65535, 1);
      offer_bpb(0, 0, 0, 0, 0, 0, 0);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0)
            no_gaps = ($urandom_range(0, 3) == 0);
         if (n == RANDOM_ITEMS / 2) begin
            // drain everything before going on
            req_tvalid <= 1'b0;
            do @(posedge clock); while (results_waiting != 0);
         end
         sb    = 512;
         spc   = 1 << $urandom_range(0, 7);
         rsv   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 32);
         nfat  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 2);
         nroot = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 512);
         fsz   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 12);
         meta  = rsv + nfat * fsz + (nroot + 15) / 16;
         if (meta >= 65535 || $urandom_range(0, 19) == 0) begin
            vol = $urandom_range(0, 65535);
         end else begin
            room = 65535 - meta;
            if (room > 4200 * spc)
               room = 4200 * spc;
            vol = meta + $urandom_range(0, room);
         end
         kind = $urandom_range(0, 99);
         if (kind >= 85) begin
            sb    = $urandom_range(0, 65535);
            spc   = $urandom_range(0, 255);
            rsv   = $urandom_range(0, 65535);
            nfat  = $urandom_range(0, 255);
            nroot = $urandom_range(0, 65535);
            vol   = $urandom_range(0, 65535);
            fsz   = $urandom_range(0, 65535);
         end else if (kind >= 70) begin
            case ($urandom_range(0, 5))
               0: sb = $urandom_range(0, 65535);
               1: spc = $urandom_range(0, 255);
               2: rsv = 0;
               3: nfat = 0;
               4: nroot = 0;
               default: fsz = 0;
            endcase
         end
         offer_bpb(16'(sb), 8'(spc), 16'(rsv), 8'(nfat), 16'(nroot), 16'(vol), 16'(fsz));
      end

      req_tvalid <= 1'b0;
      do @(posedge clock); while (results_waiting != 0);
      repeat (8) @(posedge clock);
      if (error_total == 0)
         $display("fat12_bpb_geometry_check_tb passed");
      else
         $display("fat12_bpb_geometry_check_tb failed");
      $finish;
   end

   initial begin : result_sink
      int unsigned tick, span, holds;
      tick  = 0;
      holds = 0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if ((holds == 0 && tick >= 1500) || (holds == 1 && tick >= 3500)) begin
            // long hold-off so the block backs up into the request side
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
            tick += 400;
            holds++;
         end else begin
            span = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                               : $urandom_range(1, 16);
            rsp_tready <= 1'b1;
            repeat (span) @(posedge clock);
            tick += span;
            span = pick_gap();
            if (span > 0) begin
               rsp_tready <= 1'b0;
               repeat (span) @(posedge clock);
               tick += span;
            end
         end
      end
   end

endmodule

`default_nettype wire
